// ===== rtl/core/jmbt_pkg.sv =====
// Shared types and constants for the JSON message boundary tracker.
// No dependencies; used by jmbt_tracker, the top level and the testbench.
`timescale 1ns / 1ps

package jmbt_pkg;

    // Width of the token length field
    localparam int LENGTH_WIDTH = 16;

    // Configuration port geometry
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    // Field and state widths
    localparam int KIND_WIDTH    = 3;
    localparam int BYTE_WIDTH    = 32;
    localparam int COUNT_WIDTH   = 23;
    localparam int NESTING_WIDTH = 11;
    localparam int DEPTH_WIDTH   = 12;

    // Configuration register reset values
    localparam logic [BYTE_WIDTH-1:0]    BYTE_LIMIT_RESET    = 32'd67108864;
    localparam logic [COUNT_WIDTH-1:0]   COUNT_LIMIT_RESET   = 23'd2097152;
    localparam logic [NESTING_WIDTH-1:0] NESTING_LIMIT_RESET = 11'd1024;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_BYTE_LIMIT    = 2'd0,
        CFG_COUNT_LIMIT   = 2'd1,
        CFG_NESTING_LIMIT = 2'd2
    } cfg_index_t;

    // Lexer token kinds; codes six and seven count as other
    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_OTHER        = 3'd0,
        KIND_OPEN_CURLY   = 3'd1,
        KIND_CLOSE_CURLY  = 3'd2,
        KIND_OPEN_SQUARE  = 3'd3,
        KIND_CLOSE_SQUARE = 3'd4,
        KIND_ERROR        = 3'd5
    } token_kind_t;

    // Per-token verdict passed from the tracker to the output stage
    typedef struct packed {
        logic message_end;
        logic message_bad;
    } verdict_t;

endpackage

// ===== rtl/core/jmbt_tracker.sv =====
// Message state and limit registers with the per-token boundary decision.
// Depends on jmbt_pkg for widths, token kinds, register indexes and verdict_t.
`timescale 1ns / 1ps

module jmbt_tracker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write,
    input  logic [jmbt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [jmbt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                 token_accept,
    input  logic [jmbt_pkg::KIND_WIDTH-1:0]      token_kind,
    input  logic [jmbt_pkg::LENGTH_WIDTH-1:0]    token_length,
    output jmbt_pkg::verdict_t                   verdict
);

    localparam int DW = jmbt_pkg::DEPTH_WIDTH;
    localparam int BW = jmbt_pkg::BYTE_WIDTH;
    localparam int CW = jmbt_pkg::COUNT_WIDTH;
    localparam int NW = jmbt_pkg::NESTING_WIDTH;

    logic [BW-1:0] byte_limit_reg;
    logic [CW-1:0] count_limit_reg;
    logic [NW-1:0] nesting_limit_reg;

    logic [DW-1:0] curly_reg,  curly_next;
    logic [DW-1:0] square_reg, square_next;
    logic [BW-1:0] byte_total_reg,  byte_total_next;
    logic [CW-1:0] token_total_reg, token_total_next;

    logic signed [DW:0] curly_new, square_new;
    logic [DW:0]        depth_sum;
    logic [BW:0]        byte_sum;
    logic [BW-1:0]      byte_new;
    logic [CW-1:0]      token_new;
    logic               is_error, went_negative, both_zero, over_limit;
    logic               msg_end, msg_bad;

    // Hold the limit registers; ignore indexes past the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_limit_reg    <= jmbt_pkg::BYTE_LIMIT_RESET;
            count_limit_reg   <= jmbt_pkg::COUNT_LIMIT_RESET;
            nesting_limit_reg <= jmbt_pkg::NESTING_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                jmbt_pkg::CFG_BYTE_LIMIT:    byte_limit_reg    <= cfg_data[BW-1:0];
                jmbt_pkg::CFG_COUNT_LIMIT:   count_limit_reg   <= cfg_data[CW-1:0];
                jmbt_pkg::CFG_NESTING_LIMIT: nesting_limit_reg <= cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // Step the depths by token kind; stored depths are never negative
    always_comb begin
        curly_new  = $signed({1'b0, curly_reg});
        square_new = $signed({1'b0, square_reg});
        case (token_kind)
            jmbt_pkg::KIND_OPEN_CURLY:   curly_new  = curly_new  + (DW+1)'(1);
            jmbt_pkg::KIND_CLOSE_CURLY:  curly_new  = curly_new  - (DW+1)'(1);
            jmbt_pkg::KIND_OPEN_SQUARE:  square_new = square_new + (DW+1)'(1);
            jmbt_pkg::KIND_CLOSE_SQUARE: square_new = square_new - (DW+1)'(1);
            default: ;
        endcase
    end

    // Saturating byte and token totals
    assign byte_sum  = {1'b0, byte_total_reg} + (BW+1)'(token_length);
    assign byte_new  = byte_sum[BW] ? {BW{1'b1}} : byte_sum[BW-1:0];
    assign token_new = (&token_total_reg) ? token_total_reg
                                          : token_total_reg + CW'(1);

    // Decide the message boundary in priority order
    assign depth_sum     = $unsigned(curly_new) + $unsigned(square_new);
    assign is_error      = (token_kind == jmbt_pkg::KIND_ERROR);
    assign went_negative = curly_new[DW] | square_new[DW];
    assign both_zero     = (curly_new == '0) && (square_new == '0);
    assign over_limit    = (byte_new > byte_limit_reg) || (token_new > count_limit_reg)
                        || (depth_sum > (DW+1)'(nesting_limit_reg));

    assign msg_end = is_error || went_negative || both_zero || over_limit;
    assign msg_bad = is_error || (!went_negative && !both_zero && over_limit);

    assign verdict.message_end = msg_end;
    assign verdict.message_bad = msg_bad;

    // Clear on any end, else carry the updated message state
    always_comb begin
        curly_next       = curly_reg;
        square_next      = square_reg;
        byte_total_next  = byte_total_reg;
        token_total_next = token_total_reg;
        if (token_accept) begin
            if (msg_end) begin
                curly_next       = '0;
                square_next      = '0;
                byte_total_next  = '0;
                token_total_next = '0;
            end else begin
                curly_next       = curly_new[DW-1:0];
                square_next      = square_new[DW-1:0];
                byte_total_next  = byte_new;
                token_total_next = token_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curly_reg       <= '0;
            square_reg      <= '0;
            byte_total_reg  <= '0;
            token_total_reg <= '0;
        end else begin
            curly_reg       <= curly_next;
            square_reg      <= square_next;
            byte_total_reg  <= byte_total_next;
            token_total_reg <= token_total_next;
        end
    end

endmodule

// ===== rtl/core/json_message_boundary_tracker.sv =====
// JSON message boundary tracker: top level with handshakes and output register.
// Depends on jmbt_pkg and jmbt_tracker.
//
// Usage: lexer tokens enter on the s_ channel (s_token_kind, s_token_length)
// with s_valid/s_ready. Each accepted token yields exactly one result on the
// m_ channel: m_message_end flags the token that closes a message, and
// m_message_bad flags a message whose tokens downstream must discard.
// Limits are written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high, and writes belong in idle periods between messages.
// The result is captured in the output register in the cycle after the token
// is accepted. Throughput: one token per cycle while the result channel does
// not stall; a single register stage holds the depth, byte and token counters.
// Stall: while m_valid is high and m_ready low, s_ready drops; s_ready follows
// m_ready combinationally, so a result taken frees the slot in the same cycle.
// Reset (aresetn low at a clock edge): depths and totals clear, limits return
// to their defaults and the output register empties.
`timescale 1ns / 1ps

module json_message_boundary_tracker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jmbt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [jmbt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [jmbt_pkg::KIND_WIDTH-1:0]      s_token_kind,
    input  logic [jmbt_pkg::LENGTH_WIDTH-1:0]    s_token_length,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_message_end,
    output logic                                 m_message_bad
);

    logic               m_valid_reg, m_valid_next;
    jmbt_pkg::verdict_t result_reg;
    jmbt_pkg::verdict_t verdict;
    logic               token_accept;

    assign cfg_ready    = 1'b1;
    assign s_ready      = !m_valid_reg || m_ready;
    assign token_accept = s_valid && s_ready;

    jmbt_tracker u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .token_accept (token_accept),
        .token_kind   (s_token_kind),
        .token_length (s_token_length),
        .verdict      (verdict)
    );

    // Fill on each accepted transaction, drain when the receiver takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (token_accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the verdict with the transaction
    always_ff @(posedge aclk) begin
        if (token_accept) begin
            result_reg <= verdict;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_message_end = result_reg.message_end;
    assign m_message_bad = result_reg.message_bad;

endmodule

// ===== rtl/core/jmbt_checker.sv =====
// Port-level assertions for the JSON message boundary tracker, bound to the top.
// Watches the token handshake and the result channel of the top level.
`timescale 1ns / 1ps

module jmbt_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_message_end,
    input logic m_message_bad
);

    // A bad verdict always closes the message
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_message_bad || m_message_end))
        else $error("message_bad without message_end");

    // Every accepted token produces a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted token produced no result");

    // A stalled result must block new tokens
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted over a stalled result");

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_message_end)
                                   && $stable(m_message_bad)))
        else $error("stalled result changed");

endmodule

bind json_message_boundary_tracker jmbt_checker u_jmbt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_message_end (m_message_end),
    .m_message_bad (m_message_bad)
);

// ===== tb/sv/json_message_boundary_tracker_test.sv =====
`timescale 1ns / 1ps
// Testbench for json_message_boundary_tracker: directed token table, then random
// message traffic under several limit settings, checked by a cycle-free tracker model.
// Depends on jmbt_pkg and the json_message_boundary_tracker RTL.

module json_message_boundary_tracker_test;
    import jmbt_pkg::*;

    // Kind codes outside the named set; the block treats them as other
    localparam logic [KIND_WIDTH-1:0] KIND_SPARE_LOW  = 3'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_SPARE_HIGH = 3'd7;
    // Register index past the last limit; writes to it are dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;
    localparam logic [BYTE_WIDTH-1:0]   BYTE_SATURATED = '1;
    localparam logic [COUNT_WIDTH-1:0]  COUNT_SATURATED = '1;

    localparam verdict_t NO_END   = 2'b00;
    localparam verdict_t GOOD_END = 2'b10;
    localparam verdict_t BAD_END  = 2'b11;

    localparam int IDLE_PCT     = 19;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [KIND_WIDTH-1:0]      s_token_kind;
    logic [LENGTH_WIDTH-1:0]    s_token_length;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_message_end;
    logic                       m_message_bad;

    json_message_boundary_tracker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_token_kind  (s_token_kind),
        .s_token_length(s_token_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_message_end (m_message_end),
        .m_message_bad (m_message_bad)
    );

    // Tracker model state and limits
    int                       open_curly = 0;
    int                       open_square = 0;
    logic [BYTE_WIDTH-1:0]    message_bytes = '0;
    logic [COUNT_WIDTH-1:0]   message_tokens = '0;
    logic [BYTE_WIDTH-1:0]    max_bytes = BYTE_LIMIT_RESET;
    logic [COUNT_WIDTH-1:0]   max_tokens = COUNT_LIMIT_RESET;
    logic [NESTING_WIDTH-1:0] depth_cap = NESTING_LIMIT_RESET;

    verdict_t pending_verdicts[$];
    verdict_t expected_verdict;
    int       tokens_sent = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       send_idle_pct = IDLE_PCT;
    int       recv_idle_pct = IDLE_PCT;

    // Directed token table; typed verdicts are checked as written
    typedef struct packed {
        logic [KIND_WIDTH-1:0]   kind;
        logic [LENGTH_WIDTH-1:0] len;
        logic                    typed;
        verdict_t                verdict;
    } token_row_t;

    token_row_t directed_tokens [22] = '{
        '{KIND_OTHER,        16'd0,      1'b1, GOOD_END}, // bare value right after reset
        '{KIND_OPEN_CURLY,   16'd1,      1'b1, NO_END},
        '{KIND_OTHER,        LENGTH_MAX, 1'b1, NO_END},
        '{KIND_CLOSE_CURLY,  16'd1,      1'b1, GOOD_END},
        '{KIND_OPEN_SQUARE,  16'd1,      1'b0, NO_END},
        '{KIND_OPEN_CURLY,   16'h5555,   1'b0, NO_END},
        '{KIND_CLOSE_CURLY,  16'hAAAA,   1'b0, NO_END},
        '{KIND_CLOSE_SQUARE, 16'd1,      1'b1, GOOD_END},
        '{KIND_CLOSE_CURLY,  16'd1,      1'b1, GOOD_END}, // stray closer, depth goes negative
        '{KIND_CLOSE_SQUARE, 16'd0,      1'b1, GOOD_END},
        '{KIND_OPEN_CURLY,   16'd2,      1'b0, NO_END},
        '{KIND_ERROR,        16'd7,      1'b1, BAD_END},  // lexer error inside a message
        '{KIND_ERROR,        16'd0,      1'b1, BAD_END},  // error wins over zero depth
        '{KIND_SPARE_LOW,    16'h5555,   1'b1, GOOD_END},
        '{KIND_SPARE_HIGH,   16'hAAAA,   1'b1, GOOD_END},
        '{KIND_OPEN_SQUARE,  16'd1,      1'b0, NO_END},
        '{KIND_SPARE_LOW,    16'd3,      1'b0, NO_END},
        '{KIND_CLOSE_CURLY,  16'd1,      1'b1, GOOD_END}, // wrong closer under an open square
        '{KIND_OPEN_CURLY,   LENGTH_MAX, 1'b0, NO_END},
        '{KIND_OPEN_SQUARE,  LENGTH_MAX, 1'b0, NO_END},
        '{KIND_CLOSE_SQUARE, 16'd1,      1'b0, NO_END},
        '{KIND_CLOSE_CURLY,  16'd1,      1'b1, GOOD_END}
    };

    // Clock: 2 ns period
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Advance the tracker by one token and return its verdict
    function automatic verdict_t track_token(input logic [KIND_WIDTH-1:0] kind,
                                             input logic [LENGTH_WIDTH-1:0] len);
        int              curly;
        int              square;
        logic [BYTE_WIDTH:0] sum;
        verdict_t        verdict;
        curly = open_curly;
        square = open_square;
        verdict = NO_END;
        case (kind)
            KIND_OPEN_CURLY:   curly = curly + 1;
            KIND_CLOSE_CURLY:  curly = curly - 1;
            KIND_OPEN_SQUARE:  square = square + 1;
            KIND_CLOSE_SQUARE: square = square - 1;
            default: ;
        endcase
        sum = {1'b0, message_bytes} + len;
        message_bytes = sum[BYTE_WIDTH] ? BYTE_SATURATED : sum[BYTE_WIDTH-1:0];
        if (message_tokens != COUNT_SATURATED) begin
            message_tokens = message_tokens + 1'b1;
        end
        open_curly = curly;
        open_square = square;
        if (kind == KIND_ERROR) begin
            verdict = BAD_END;
        end else if (curly < 0 || square < 0 || (curly == 0 && square == 0)) begin
            verdict = GOOD_END;
        end else if (message_bytes > max_bytes || message_tokens > max_tokens ||
                     (curly + square) > int'(depth_cap)) begin
            verdict = BAD_END;
        end
        // Any message end clears the tracker
        if (verdict.message_end) begin
            open_curly = 0;
            open_square = 0;
            message_bytes = '0;
            message_tokens = '0;
        end
        return verdict;
    endfunction

    function automatic logic [LENGTH_WIDTH-1:0] random_length();
        case ($urandom_range(9))
            0:       return '0;
            1:       return LENGTH_MAX;
            2, 3:    return LENGTH_WIDTH'($urandom);
            default: return LENGTH_WIDTH'($urandom_range(1, 40));
        endcase
    endfunction

    // Present one token; entered and left at a falling edge, valid left high
    task automatic send_token(input logic [KIND_WIDTH-1:0] kind,
                              input logic [LENGTH_WIDTH-1:0] len,
                              input logic typed = 1'b0,
                              input verdict_t typed_verdict = NO_END);
        verdict_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_token_kind <= kind;
        s_token_length <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = track_token(kind, len);
        pending_verdicts.push_back(typed ? typed_verdict : predicted);
        tokens_sent++;
        @(negedge aclk);
    endtask

    // Hold the sender until every outstanding transaction has returned
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_verdicts.size() != 0) @(negedge aclk);
    endtask

    // Write one limit register; only called while the block is idle
    task automatic write_limit(input logic [CFG_INDEX_WIDTH-1:0] idx,
                               input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_BYTE_LIMIT:    max_bytes = data;
            CFG_COUNT_LIMIT:   max_tokens = data[COUNT_WIDTH-1:0];
            CFG_NESTING_LIMIT: depth_cap = data[NESTING_WIDTH-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // One nested message with random content, with the odd stray token mixed in
    task automatic send_message();
        logic [KIND_WIDTH-1:0] opened[$];
        logic [KIND_WIDTH-1:0] top;
        int                    pick;
        top = $urandom_range(1) ? KIND_OPEN_CURLY : KIND_OPEN_SQUARE;
        opened.push_back(top);
        send_token(top, random_length());
        repeat ($urandom_range(0, 12)) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_token(KIND_WIDTH'($urandom_range(7)), random_length());
            end else if (pick < 30 && opened.size() < 6) begin
                top = $urandom_range(1) ? KIND_OPEN_CURLY : KIND_OPEN_SQUARE;
                opened.push_back(top);
                send_token(top, random_length());
            end else if (pick < 50 && opened.size() > 1) begin
                top = opened.pop_back();
                send_token(top == KIND_OPEN_CURLY ? KIND_CLOSE_CURLY : KIND_CLOSE_SQUARE,
                           random_length());
            end else begin
                send_token(KIND_OTHER, random_length());
            end
        end
        // Close whatever is still open, innermost first
        while (opened.size() != 0) begin
            top = opened.pop_back();
            send_token(top == KIND_OPEN_CURLY ? KIND_CLOSE_CURLY : KIND_CLOSE_SQUARE,
                       random_length());
        end
    endtask

    // Mostly well-formed messages, some raw tokens, and the occasional full drain
    task automatic random_traffic(input int n_items);
        int target;
        target = tokens_sent + n_items;
        while (tokens_sent < target) begin
            if ($urandom_range(99) < 3) begin
                wait_drained();
            end
            if ($urandom_range(99) < 80) begin
                send_message();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_token(KIND_WIDTH'($urandom_range(7)), random_length());
                end
            end
        end
    endtask

    // Result side: stall at random, change at the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transaction with the oldest predicted verdict
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, end %0b bad %0b",
                         $time, m_message_end, m_message_bad);
            end else begin
                expected_verdict = pending_verdicts.pop_front();
                if (m_message_end !== expected_verdict.message_end) begin
                    mismatches++;
                    $display("%0t: message_end expected %0b, got %0b",
                             $time, expected_verdict.message_end, m_message_end);
                end
                if (m_message_bad !== expected_verdict.message_bad) begin
                    mismatches++;
                    $display("%0t: message_bad expected %0b, got %0b",
                             $time, expected_verdict.message_bad, m_message_bad);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_token_kind = '0;
        s_token_length = '0;
        m_ready = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed tokens at the reset limits
        foreach (directed_tokens[i]) begin
            send_token(directed_tokens[i].kind, directed_tokens[i].len,
                       directed_tokens[i].typed, directed_tokens[i].verdict);
        end
        random_traffic(80);
        wait_drained();

        // Tight limits: messages regularly run into each of them
        write_limit(CFG_BYTE_LIMIT, 32'd200);
        write_limit(CFG_COUNT_LIMIT, 32'd6);
        write_limit(CFG_NESTING_LIMIT, 32'd3);
        random_traffic(80);
        wait_drained();

        // Zero limits; the unused index must leave them alone
        write_limit(CFG_BYTE_LIMIT, 32'd0);
        write_limit(CFG_COUNT_LIMIT, 32'd0);
        write_limit(CFG_NESTING_LIMIT, 32'd0);
        write_limit(CFG_UNUSED, '1);
        random_traffic(40);
        wait_drained();

        // All-ones writes land as the widest limits; run without any stalls
        write_limit(CFG_BYTE_LIMIT, '1);
        write_limit(CFG_COUNT_LIMIT, '1);
        write_limit(CFG_NESTING_LIMIT, '1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(80);
        wait_drained();

        // Clear with an error, then nest to the combined depth limit and one past it
        write_limit(CFG_NESTING_LIMIT, 32'd24);
        send_token(KIND_ERROR, 16'd0);
        repeat (12) send_token(KIND_OPEN_CURLY, 16'd1);
        repeat (13) send_token(KIND_OPEN_SQUARE, 16'd1);
        wait_drained();
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;

        // Byte total right at its limit, then one byte past it
        write_limit(CFG_COUNT_LIMIT, 32'd4194304);
        write_limit(CFG_BYTE_LIMIT, 32'd196605);
        send_token(KIND_ERROR, 16'd0);
        send_token(KIND_OPEN_CURLY, 16'd0);
        repeat (3) send_token(KIND_OTHER, LENGTH_MAX);
        send_token(KIND_OTHER, 16'd1);
        wait_drained();

        // Random small limits
        repeat (3) begin
            write_limit(CFG_BYTE_LIMIT, $urandom_range(0, 4000));
            write_limit(CFG_COUNT_LIMIT, $urandom_range(0, 40));
            write_limit(CFG_NESTING_LIMIT, $urandom_range(0, 12));
            random_traffic(60);
            wait_drained();
        end

        // Fully random register data, masked to each register width
        write_limit(CFG_BYTE_LIMIT, $urandom);
        write_limit(CFG_COUNT_LIMIT, $urandom);
        write_limit(CFG_NESTING_LIMIT, $urandom);
        random_traffic(50);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/jmbt_pkg.sv
rtl/core/jmbt_tracker.sv
rtl/core/json_message_boundary_tracker.sv
rtl/core/jmbt_checker.sv
tb/sv/json_message_boundary_tracker_test.sv
